>>> rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and codes for the double-ended queue and its storage cells
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   // request operation codes
   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [DATA_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   popped_value;
      status_type                 status;
      logic [COUNT_W-1:0]         count;
   } rsp_type;

   // what every cell of the chain does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD        = 2'd0,
      CELL_SHIFT_BACK  = 2'd1,
      CELL_SHIFT_FRONT = 2'd2,
      CELL_LOAD_TAIL   = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type                op;
      logic signed [DATA_W-1:0]   value;
   } cell_ctrl_type;

endpackage

>>> rtl/core/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// one storage slot of the queue chain, fed by its front and back neighbors
// ----------------------------------------------------------------------------
module dq_cell #(
   parameter int INDEX  = 0,
   parameter int FILL_W = 5
) (
   input  logic                                clock,
   input  dq_pkg::cell_ctrl_type               ctrl,
   input  logic [FILL_W-1:0]                   fill,
   input  logic signed [dq_pkg::DATA_W-1:0]    front_data,
   input  logic signed [dq_pkg::DATA_W-1:0]    back_data,
   output logic signed [dq_pkg::DATA_W-1:0]    data
);

   logic signed [dq_pkg::DATA_W-1:0] data_ff;
   logic signed [dq_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         dq_pkg::CELL_SHIFT_BACK: begin
            data_in = front_data;
         end
         dq_pkg::CELL_SHIFT_FRONT: begin
            data_in = back_data;
         end
         dq_pkg::CELL_LOAD_TAIL: begin
            // first free slot takes the value
            if (fill == FILL_W'(INDEX)) begin
               data_in = ctrl.value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit values held in a chain of shifting cells
// ----------------------------------------------------------------------------
// response: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle while the response side is not stalled;
//   every cell moves one step per cycle, so the chain shift sets the rate
// reset: synchronous, clears the fill count and the response valid; the
//   queue comes up empty, cell contents are left as they are
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dq_pkg::req_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dq_pkg::rsp_type  rsp_data
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   // cell 0 always holds the front entry, cell fill-1 the back entry
   logic signed [dq_pkg::DATA_W-1:0] cell_data  [DEPTH];
   logic signed [dq_pkg::DATA_W-1:0] front_link [DEPTH];
   logic signed [dq_pkg::DATA_W-1:0] back_link  [DEPTH];

   dq_pkg::cell_ctrl_type            cell_ctrl;
   logic [FILL_W-1:0]                fill_ff;
   logic [FILL_W-1:0]                fill_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   dq_pkg::rsp_type                  rsp_ff;
   dq_pkg::rsp_type                  rsp_in;

   logic                             accept;
   logic                             full;
   logic                             empty;
   logic signed [dq_pkg::DATA_W-1:0] tail_value;
   logic [31:0]                      fill_wide;

   // request taken unless a finished response is still blocked
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (fill_ff == FILL_W'(DEPTH));
   assign empty = (fill_ff == '0);

   // neighbor links: push front feeds the new value into cell 0,
   // pop front pulls zero into the last cell
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign front_link[g] = req_data.value;
         end else begin : g_mid
            assign front_link[g] = cell_data[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign back_link[g] = '0;
         end else begin : g_inner
            assign back_link[g] = cell_data[g+1];
         end

         dq_cell #(
            .INDEX  (g),
            .FILL_W (FILL_W)
         ) u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .fill       (fill_ff),
            .front_data (front_link[g]),
            .back_data  (back_link[g]),
            .data       (cell_data[g])
         );
      end
   endgenerate

   // back entry picked by a one-hot and-or over the cells
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (fill_ff == FILL_W'(i + 1)) begin
            tail_value = tail_value | cell_data[i];
         end
      end
   end

   // operation decode
   always_comb begin
      cell_ctrl.op        = dq_pkg::CELL_HOLD;
      cell_ctrl.value     = req_data.value;
      fill_in             = fill_ff;
      rsp_in.popped_value = '0;
      rsp_in.status       = dq_pkg::STATUS_DONE;
      if (accept) begin
         case (req_data.kind)
            dq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  rsp_in.status = dq_pkg::STATUS_FULL;
               end else begin
                  cell_ctrl.op = dq_pkg::CELL_SHIFT_BACK;
                  fill_in      = fill_ff + FILL_W'(1);
               end
            end
            dq_pkg::KIND_PUSH_BACK: begin
               if (full) begin
                  rsp_in.status = dq_pkg::STATUS_FULL;
               end else begin
                  cell_ctrl.op = dq_pkg::CELL_LOAD_TAIL;
                  fill_in      = fill_ff + FILL_W'(1);
               end
            end
            dq_pkg::KIND_POP_FRONT: begin
               if (empty) begin
                  rsp_in.status = dq_pkg::STATUS_EMPTY;
               end else begin
                  cell_ctrl.op        = dq_pkg::CELL_SHIFT_FRONT;
                  rsp_in.popped_value = cell_data[0];
                  fill_in             = fill_ff - FILL_W'(1);
               end
            end
            dq_pkg::KIND_POP_BACK: begin
               // cells hold; only the count drops
               if (empty) begin
                  rsp_in.status = dq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_in.popped_value = tail_value;
                  fill_in             = fill_ff - FILL_W'(1);
               end
            end
            default: begin
               cell_ctrl.op = dq_pkg::CELL_HOLD;
            end
         endcase
      end
      // count is the new fill cut to the response field width
      fill_wide    = 32'(fill_in);
      rsp_in.count = fill_wide[dq_pkg::COUNT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // every accepted request leaves a response behind
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // fill never exceeds the cell count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill count beyond depth");

   // a dropped push means the queue really was full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_in.status == dq_pkg::STATUS_FULL |=> fill_ff == FILL_W'(DEPTH))
      else $error("full status on a queue with room");

   // an empty pop leaves the queue empty
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_in.status == dq_pkg::STATUS_EMPTY |=> fill_ff == '0)
      else $error("empty status on a queue holding entries");
`endif

endmodule

>>> dv/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// drives push and pop requests at both ends of the deque, predicts every
// response with a behavioral ring buffer, and checks the responses in order
// while both the request and the response side idle at random
// ----------------------------------------------------------------------------
module double_ended_queue_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 16;
   localparam int PTR_W        = $clog2(DEPTH);
   localparam int RANDOM_ITEMS = 1000;
   localparam int REPORT_MAX   = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 1000;
   localparam int NUM_ROWS     = 25;

   // one row of the directed table; answer is used only when has_answer is set
   typedef struct packed {
      dq_pkg::kind_type                   kind;
      logic signed [dq_pkg::DATA_W-1:0]   value;
      logic                               has_answer;
      dq_pkg::rsp_type                    answer;
   } directed_row_type;

   // opening sequence: pops on the empty queue, extremes at both ends, removing
   // the last entry from the opposite end, then filling to the top and one more
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{dq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_EMPTY, 5'd0}},
      '{dq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_EMPTY, 5'd0}},
      '{dq_pkg::KIND_PUSH_BACK,  32'h7fff_ffff, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_DONE,  5'd1}},
      '{dq_pkg::KIND_PUSH_FRONT, 32'h8000_0000, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_DONE,  5'd2}},
      '{dq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b1,
        '{32'h7fff_ffff, dq_pkg::STATUS_DONE,  5'd1}},
      '{dq_pkg::KIND_POP_FRONT,  32'hffff_ffff, 1'b1,
        '{32'h8000_0000, dq_pkg::STATUS_DONE,  5'd0}},
      '{dq_pkg::KIND_PUSH_FRONT, 32'hffff_ffff, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_DONE,  5'd1}},
      '{dq_pkg::KIND_POP_BACK,   32'h0000_0000, 1'b1,
        '{32'hffff_ffff, dq_pkg::STATUS_DONE,  5'd0}},
      '{dq_pkg::KIND_PUSH_BACK,  32'h0000_0000, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_DONE,  5'd1}},
      '{dq_pkg::KIND_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_BACK,  32'haaaa_5555, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_FRONT, 32'h5555_aaaa, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_BACK,  32'h0f0f_f0f0, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_FRONT, 32'hf0f0_0f0f, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_FRONT, 32'h8765_4321, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_BACK,  32'h7fff_fffe, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_FRONT, 32'h8000_0001, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_BACK,  32'hdead_0000, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_FRONT, 32'h0000_beef, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_BACK,  32'hffff_0000, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_FRONT, 32'h0000_ffff, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_BACK,  32'h3c3c_c3c3, 1'b0, '0},
      '{dq_pkg::KIND_PUSH_FRONT, 32'hc3c3_3c3c, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_DONE,  5'd16}},
      '{dq_pkg::KIND_PUSH_BACK,  32'h0000_1234, 1'b1,
        '{32'h0000_0000, dq_pkg::STATUS_FULL,  5'd16}}
   };

   logic            clock;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   dq_pkg::req_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   dq_pkg::rsp_type rsp_data;

   // shadow of the deque: ring store, front entry, slot after the back entry
   logic signed [dq_pkg::DATA_W-1:0] shadow_slots [DEPTH];
   logic [PTR_W-1:0]                 shadow_front = '0;
   logic [PTR_W-1:0]                 shadow_back  = '0;
   int unsigned                      shadow_fill  = 0;

   dq_pkg::rsp_type pending_responses [$];
   int              mismatch_count = 0;
   int              idle_cycles    = 0;
   logic            req_calm       = 1'b0;

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // apply one request to the shadow deque and return the response it owes;
   // pointers wrap on their own since DEPTH is a power of two
   function automatic dq_pkg::rsp_type deque_apply(dq_pkg::req_type r);
      dq_pkg::rsp_type o;
      o = '0;
      o.status = dq_pkg::STATUS_DONE;
      case (r.kind)
         dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
            if (shadow_fill == DEPTH) begin
               o.status = dq_pkg::STATUS_FULL;       // dropped, nothing moves
            end else if (r.kind == dq_pkg::KIND_PUSH_FRONT) begin
               shadow_front = shadow_front - 1'b1;
               shadow_slots[shadow_front] = r.value;
               shadow_fill++;
            end else begin
               shadow_slots[shadow_back] = r.value;
               shadow_back = shadow_back + 1'b1;
               shadow_fill++;
            end
         end
         default: begin
            if (shadow_fill == 0) begin
               o.status = dq_pkg::STATUS_EMPTY;      // popped value stays zero
            end else if (r.kind == dq_pkg::KIND_POP_FRONT) begin
               o.popped_value = shadow_slots[shadow_front];
               shadow_front = shadow_front + 1'b1;
               shadow_fill--;
            end else begin
               shadow_back = shadow_back - 1'b1;
               o.popped_value = shadow_slots[shadow_back];
               shadow_fill--;
            end
         end
      endcase
      o.count = dq_pkg::COUNT_W'(shadow_fill);
      return o;
   endfunction

   // random wait drawn per call, none at all during a calm stretch
   function automatic int draw_wait(logic calm);
      return calm ? 0 : int'($urandom_range(15));
   endfunction

   // random push value, leaning now and then on the corners of the range
   function automatic logic signed [dq_pkg::DATA_W-1:0] draw_value();
      case ($urandom_range(15))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // offer one request, hold it until accepted, then queue what it must return;
   // valid is lowered only when a gap follows, so back-to-back requests keep it
   // high without a second assignment in the same step
   task automatic send_request(dq_pkg::req_type r, logic has_answer,
                               dq_pkg::rsp_type answer);
      int              gap;
      dq_pkg::rsp_type predicted;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      // accepted at this edge: the shadow always advances, table rows with a
      // typed answer replace the prediction
      predicted = deque_apply(r);
      pending_responses.push_back(has_answer ? answer : predicted);
   endtask

   task automatic note_failure(string what, dq_pkg::rsp_type want,
                               dq_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display({"%0t: %s expected value %0d status %0d count %0d, ",
                   "got value %0d status %0d count %0d"},
                  $realtime, what, want.popped_value, want.status, want.count,
                  got.popped_value, got.status, got.count);
   endtask

   // response side: a fresh stall draw per response, with calm stretches
   initial begin : response_pacing
      int   wait_cycles;
      int   stretch_left;
      logic rsp_calm;
      rsp_calm     = 1'b0;
      stretch_left = 0;
      @(negedge reset);
      forever begin
         if (stretch_left == 0) begin
            rsp_calm     = ($urandom_range(2) == 0);
            stretch_left = $urandom_range(20, 60);
         end
         stretch_left--;
         wait_cycles = draw_wait(rsp_calm);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare every accepted response with the oldest outstanding one
   always @(posedge clock) begin
      dq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            note_failure("response with nothing outstanding:", '0, rsp_data);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.popped_value !== want.popped_value ||
                rsp_data.status !== want.status ||
                rsp_data.count !== want.count)
               note_failure("response mismatch:", want, rsp_data);
         end
      end
   end

   // watchdog: too long without any handshake means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      dq_pkg::req_type r;
      int              sent;
      int              push_pct;
      int              burst_len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table first
      for (int i = 0; i < NUM_ROWS; i++) begin
         r.kind  = DIRECTED_ROWS[i].kind;
         r.value = DIRECTED_ROWS[i].value;
         send_request(r, DIRECTED_ROWS[i].has_answer, DIRECTED_ROWS[i].answer);
      end

      // random bursts, each leaning toward pushes, pops or neither, so the
      // queue keeps running into full and into empty at both ends
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(2))
            0:       push_pct = 15;
            1:       push_pct = 50;
            default: push_pct = 85;
         endcase
         burst_len = $urandom_range(10, 60);
         req_calm  = ($urandom_range(3) == 0);
         repeat (burst_len) begin
            if ($urandom_range(99) < push_pct)
               r.kind = $urandom_range(1) ? dq_pkg::KIND_PUSH_BACK
                                          : dq_pkg::KIND_PUSH_FRONT;
            else
               r.kind = $urandom_range(1) ? dq_pkg::KIND_POP_BACK
                                          : dq_pkg::KIND_POP_FRONT;
            r.value = draw_value();
            send_request(r, 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;

      // drain, then give any stray response a chance to show up
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
